// File: src/ifp_pkg.sv
package ifp_pkg;

  localparam int SHORT_FRAME_BYTES = 20;
  localparam int LONG_FRAME_BYTES  = 44;

  localparam logic [5:0] SHORT_LEN = 6'(SHORT_FRAME_BYTES);
  localparam logic [5:0] LONG_LEN  = 6'(LONG_FRAME_BYTES);

  localparam int WORD_IDX_W = 5;
  localparam int SLOTS      = 2;
  localparam int MEM_DEPTH  = SLOTS * (1 << WORD_IDX_W);

  typedef logic [WORD_IDX_W-1:0] word_idx_t;
  typedef logic [1:0]            cfg_idx_t;
  typedef logic [3:0]            item_idx_t;

  localparam cfg_idx_t CFG_SYNC       = 2'd0;
  localparam cfg_idx_t CFG_SHORT_TYPE = 2'd1;
  localparam cfg_idx_t CFG_LONG_TYPE  = 2'd2;

  localparam logic [7:0] SYNC_RESET       = 8'd14;
  localparam logic [7:0] SHORT_TYPE_RESET = 8'd1;
  localparam logic [7:0] LONG_TYPE_RESET  = 8'd2;

  localparam item_idx_t ITEM_GYRO_X   = 4'd0;
  localparam item_idx_t ITEM_GYRO_Y   = 4'd1;
  localparam item_idx_t ITEM_GYRO_Z   = 4'd2;
  localparam item_idx_t ITEM_ACCEL_X  = 4'd3;
  localparam item_idx_t ITEM_ACCEL_Y  = 4'd4;
  localparam item_idx_t ITEM_ACCEL_Z  = 4'd5;
  localparam item_idx_t ITEM_STATUS1  = 4'd6;
  localparam item_idx_t ITEM_STATUS2  = 4'd7;
  localparam item_idx_t ITEM_TEMP     = 4'd8;
  localparam item_idx_t ITEM_DANG_X   = 4'd9;
  localparam item_idx_t ITEM_DANG_Y   = 4'd10;
  localparam item_idx_t ITEM_DANG_Z   = 4'd11;
  localparam item_idx_t ITEM_DVEL_X   = 4'd12;
  localparam item_idx_t ITEM_DVEL_Y   = 4'd13;
  localparam item_idx_t ITEM_DVEL_Z   = 4'd14;

  localparam item_idx_t LAST_SHORT = ITEM_TEMP;
  localparam item_idx_t LAST_LONG  = ITEM_DVEL_Z;

  typedef enum logic [1:0] {
    CLS_SWORD,
    CLS_UWORD,
    CLS_TEMP,
    CLS_PAIR
  } item_cls_t;

  typedef struct packed {
    logic      wr_en;
    word_idx_t wr_word;
    logic [15:0] wr_data;
    logic      commit;
    logic      commit_long;
  } fq_wr_t;

  typedef struct packed {
    logic      rd_en;
    word_idx_t rd_word;
    logic      pop;
  } bq_req_t;

  typedef struct packed {
    logic        avail;
    logic        head_long;
    logic [15:0] lo_data;
    logic [15:0] hi_data;
  } qb_rsp_t;

  typedef struct packed {
    word_idx_t word;
    logic      neg;
    item_cls_t cls;
  } item_map_t;

  function automatic item_map_t item_map(input item_idx_t k);
    item_map_t m;
    m = '{word: '0, neg: 1'b0, cls: CLS_TEMP};
    unique case (k)
      ITEM_GYRO_X:  m = '{word: 5'd2,  neg: 1'b1, cls: CLS_SWORD};
      ITEM_GYRO_Y:  m = '{word: 5'd3,  neg: 1'b0, cls: CLS_SWORD};
      ITEM_GYRO_Z:  m = '{word: 5'd1,  neg: 1'b1, cls: CLS_SWORD};
      ITEM_ACCEL_X: m = '{word: 5'd5,  neg: 1'b1, cls: CLS_SWORD};
      ITEM_ACCEL_Y: m = '{word: 5'd6,  neg: 1'b0, cls: CLS_SWORD};
      ITEM_ACCEL_Z: m = '{word: 5'd4,  neg: 1'b1, cls: CLS_SWORD};
      ITEM_STATUS1: m = '{word: 5'd7,  neg: 1'b0, cls: CLS_UWORD};
      ITEM_STATUS2: m = '{word: 5'd8,  neg: 1'b0, cls: CLS_UWORD};
      ITEM_TEMP:    m = '{word: 5'd0,  neg: 1'b0, cls: CLS_TEMP};
      ITEM_DANG_X:  m = '{word: 5'd11, neg: 1'b1, cls: CLS_PAIR};
      ITEM_DANG_Y:  m = '{word: 5'd13, neg: 1'b0, cls: CLS_PAIR};
      ITEM_DANG_Z:  m = '{word: 5'd9,  neg: 1'b1, cls: CLS_PAIR};
      ITEM_DVEL_X:  m = '{word: 5'd17, neg: 1'b1, cls: CLS_PAIR};
      ITEM_DVEL_Y:  m = '{word: 5'd19, neg: 1'b0, cls: CLS_PAIR};
      ITEM_DVEL_Z:  m = '{word: 5'd15, neg: 1'b1, cls: CLS_PAIR};
      default:      m = '{word: 5'd0,  neg: 1'b0, cls: CLS_TEMP};
    endcase
    return m;
  endfunction

endpackage

// File: src/ifp_front.sv
module ifp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [7:0]        in_rx_byte,
  input  logic              full,
  input  logic              cfg_valid,
  input  ifp_pkg::cfg_idx_t cfg_index,
  input  logic [7:0]        cfg_data,
  output ifp_pkg::fq_wr_t   wr
);
  import ifp_pkg::*;

  logic [7:0]  sync_r, sync_nxt;
  logic [7:0]  short_type_r, short_type_nxt;
  logic [7:0]  long_type_r, long_type_nxt;
  logic [5:0]  pos_r, pos_nxt;
  logic        long_r, long_nxt;
  logic [7:0]  lo_r, lo_nxt;
  logic [15:0] sum_r, sum_nxt;

  logic        acc;
  logic [5:0]  len;
  logic [15:0] word;

  assign acc  = in_valid && !full;
  assign len  = long_r ? LONG_LEN : SHORT_LEN;
  assign word = {in_rx_byte, lo_r};

  always_comb begin
    sync_nxt       = sync_r;
    short_type_nxt = short_type_r;
    long_type_nxt  = long_type_r;
    if (cfg_valid) begin
      case (cfg_index)
        CFG_SYNC:       sync_nxt       = cfg_data;
        CFG_SHORT_TYPE: short_type_nxt = cfg_data;
        CFG_LONG_TYPE:  long_type_nxt  = cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    pos_nxt  = pos_r;
    long_nxt = long_r;
    lo_nxt   = lo_r;
    sum_nxt  = sum_r;
    wr       = '0;
    wr.wr_word = pos_r[5:1];
    wr.wr_data = word;
    wr.commit_long = long_r;
    if (acc) begin
      if (pos_r == 6'd0) begin
        if (in_rx_byte == sync_r) begin
          pos_nxt  = 6'd1;
          long_nxt = 1'b0;
          lo_nxt   = in_rx_byte;
        end
      end else if (pos_r == 6'd1) begin
        if (in_rx_byte == short_type_r) begin
          long_nxt = 1'b0;
          pos_nxt  = 6'd2;
          sum_nxt  = word;
        end else if (in_rx_byte == long_type_r) begin
          long_nxt = 1'b1;
          pos_nxt  = 6'd2;
          sum_nxt  = word;
        end else begin
          pos_nxt = 6'd0;
        end
      end else if (pos_r >= len) begin
        pos_nxt = 6'd0;
      end else begin
        pos_nxt = pos_r + 6'd1;
        if (!pos_r[0]) begin
          lo_nxt = in_rx_byte;
        end else if (pos_r == len - 6'd1) begin
          pos_nxt   = 6'd0;
          wr.commit = (sum_r == word);
        end else begin
          sum_nxt  = sum_r + word;
          wr.wr_en = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sync_r       <= SYNC_RESET;
      short_type_r <= SHORT_TYPE_RESET;
      long_type_r  <= LONG_TYPE_RESET;
      pos_r        <= '0;
      long_r       <= 1'b0;
      sum_r        <= '0;
    end else begin
      sync_r       <= sync_nxt;
      short_type_r <= short_type_nxt;
      long_type_r  <= long_type_nxt;
      pos_r        <= pos_nxt;
      long_r       <= long_nxt;
      sum_r        <= sum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r <= lo_nxt;
  end

endmodule

// File: src/ifp_queue.sv
module ifp_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  ifp_pkg::fq_wr_t  wr,
  input  ifp_pkg::bq_req_t req,
  output logic             full,
  output ifp_pkg::qb_rsp_t rsp
);
  import ifp_pkg::*;

  logic [15:0] mem [MEM_DEPTH];
  logic [1:0]  cnt_r, cnt_nxt;
  logic        wr_ptr_r, wr_ptr_nxt;
  logic        rd_ptr_r, rd_ptr_nxt;
  logic [SLOTS-1:0] kind_r;
  logic [15:0] lo_r, hi_r;
  word_idx_t   hi_word;

  assign full    = (cnt_r == 2'd2);
  assign hi_word = req.rd_word + 5'd1;

  assign rsp.avail     = (cnt_r != 2'd0);
  assign rsp.head_long = kind_r[rd_ptr_r];
  assign rsp.lo_data   = lo_r;
  assign rsp.hi_data   = hi_r;

  always_comb begin
    cnt_nxt    = cnt_r + {1'b0, wr.commit} - {1'b0, req.pop};
    wr_ptr_nxt = wr_ptr_r ^ wr.commit;
    rd_ptr_nxt = rd_ptr_r ^ req.pop;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.commit) begin
      kind_r[wr_ptr_r] <= wr.commit_long;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.wr_en) begin
      mem[{wr_ptr_r, wr.wr_word}] <= wr.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      lo_r <= mem[{rd_ptr_r, req.rd_word}];
      hi_r <= mem[{rd_ptr_r, hi_word}];
    end
  end

endmodule

// File: src/ifp_back.sv
module ifp_back (
  input  logic                clk,
  input  logic                rst_n,
  input  ifp_pkg::qb_rsp_t    rsp,
  output ifp_pkg::bq_req_t    req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_frame_kind,
  output ifp_pkg::item_idx_t  out_item_index,
  output logic signed [32:0]  out_item_value,
  output logic                out_last_item
);
  import ifp_pkg::*;

  item_idx_t k_r, k_nxt;
  logic      s1_valid_r, s1_valid_nxt;
  item_idx_t s1_k_r;
  logic      s1_long_r;
  logic      s1_last_r;
  logic      out_valid_r, out_valid_nxt;
  logic      out_kind_r;
  item_idx_t out_index_r;
  logic signed [32:0] out_value_r;
  logic      out_last_r;
  logic [7:0] temp_r, temp_nxt;

  logic      load_out;
  logic      issue;
  item_idx_t last_k;
  item_map_t iss_map;
  item_map_t s1_map;
  logic signed [32:0] base;
  logic signed [32:0] value;

  assign load_out = !out_valid_r || !out_stall;
  assign issue    = rsp.avail && (!s1_valid_r || load_out);
  assign last_k   = rsp.head_long ? LAST_LONG : LAST_SHORT;
  assign iss_map  = item_map(k_r);
  assign s1_map   = item_map(s1_k_r);

  assign req.rd_en   = issue;
  assign req.rd_word = iss_map.word;
  assign req.pop     = issue && (k_r == last_k);

  always_comb begin
    k_nxt = k_r;
    if (issue) begin
      k_nxt = (k_r == last_k) ? '0 : k_r + 4'd1;
    end
    if (issue) begin
      s1_valid_nxt = 1'b1;
    end else if (load_out) begin
      s1_valid_nxt = 1'b0;
    end else begin
      s1_valid_nxt = s1_valid_r;
    end
    out_valid_nxt = load_out ? s1_valid_r : out_valid_r;
  end

  always_comb begin
    case (s1_map.cls)
      CLS_SWORD: base = {{17{rsp.lo_data[15]}}, rsp.lo_data};
      CLS_UWORD: base = {17'd0, rsp.lo_data};
      CLS_PAIR:  base = {rsp.hi_data[15], rsp.hi_data, rsp.lo_data};
      default:   base = {25'd0, temp_r};
    endcase
    value = s1_map.neg ? -base : base;
  end

  always_comb begin
    temp_nxt = temp_r;
    if (load_out && s1_valid_r && s1_k_r == ITEM_STATUS2 && rsp.lo_data[15]) begin
      temp_nxt = rsp.lo_data[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r         <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      temp_r      <= '0;
    end else begin
      k_r         <= k_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      temp_r      <= temp_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      s1_k_r    <= k_r;
      s1_long_r <= rsp.head_long;
      s1_last_r <= (k_r == last_k);
    end
    if (load_out && s1_valid_r) begin
      out_kind_r  <= s1_long_r;
      out_index_r <= s1_k_r;
      out_value_r <= value;
      out_last_r  <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_frame_kind = out_kind_r;
  assign out_item_index = out_index_r;
  assign out_item_value = out_value_r;
  assign out_last_item  = out_last_r;

endmodule

// File: src/imu_serial_frame_parser.sv
// Serial byte frame parser. Bytes are taken one per cycle unless in_stall is
// high; a frame starts with the sync byte, and the type byte selects a 20-byte
// short frame or a 44-byte long frame. The 16-bit word sum is kept as bytes
// arrive, and a frame whose sum matches its checksum word is handed through a
// two-slot frame buffer to the output side, which gives one result transfer
// per cycle while out_stall is low: 9 items for a short frame, 15 for a long
// one. The first item passes the frame count, buffer read and output registers
// after the checksum byte is taken. Input stalls only while both buffer slots
// hold checked frames the output side has not finished reading, so with output
// transfers taken the input runs at one byte per cycle without pause.
module imu_serial_frame_parser (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [7:0]          in_rx_byte,
  output logic                out_valid,
  input  logic                out_stall,
  output logic                out_frame_kind,
  output ifp_pkg::item_idx_t  out_item_index,
  output logic signed [32:0]  out_item_value,
  output logic                out_last_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  ifp_pkg::cfg_idx_t   cfg_index,
  input  logic [7:0]          cfg_data
);
  import ifp_pkg::*;

  fq_wr_t  wr;
  bq_req_t req;
  qb_rsp_t rsp;
  logic    full;

  assign in_stall  = full;
  assign cfg_ready = 1'b1;

  ifp_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_rx_byte (in_rx_byte),
    .full       (full),
    .cfg_valid  (cfg_valid),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .wr         (wr)
  );

  ifp_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .req   (req),
    .full  (full),
    .rsp   (rsp)
  );

  ifp_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .rsp            (rsp),
    .req            (req),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_frame_kind (out_frame_kind),
    .out_item_index (out_item_index),
    .out_item_value (out_item_value),
    .out_last_item  (out_last_item)
  );

  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last_item |->
      (out_frame_kind ? (out_item_index == LAST_LONG) : (out_item_index == LAST_SHORT)))
    else $error("last item flag on wrong index");

  a_temp_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item_index == ITEM_TEMP |-> out_item_value[32:8] == '0)
    else $error("temperature out of byte range");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_item_index == ITEM_STATUS1 || out_item_index == ITEM_STATUS2)
      |-> out_item_value[32:16] == '0)
    else $error("status word not unsigned 16 bit");

  a_short_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_frame_kind |-> out_item_index <= LAST_SHORT)
    else $error("short frame item beyond temperature");

endmodule
